FILE: hdl/sqt_pkg.sv
`timescale 1ns / 1ps

package sqt_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_OK   = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   // Special bytes
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // Plan queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_SQ     = 3'd2,
      MODE_DQ     = 3'd3,
      MODE_REDIR  = 3'd4,
      MODE_DQ_ESC = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // Results of one input byte, always in this order:
   // end before the byte, the byte, end after the byte, line status
   typedef struct packed {
      logic       pre_end;
      logic       has_byte;
      logic [7:0] data;
      logic       post_end;
      logic       has_status;
      logic       status_err;
   } plan_type;

endpackage

FILE: hdl/sqt_front.sv
`timescale 1ns / 1ps

module sqt_front
   import sqt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output plan_type q_plan
);

   mode_type mode_ff, mode_in, mode_step;
   logic     token_open_ff, token_open_in;
   logic     accept;

   logic pre_end, has_byte, redir_end, token_after;

   assign accept = req_push & ~q_full;

   // Next state: mode after this byte, then line end returns to normal
   always_comb begin
      mode_step = MODE_NORMAL;
      case (mode_ff)
         MODE_ESC: begin
            mode_step = MODE_NORMAL;
         end
         MODE_SQ: begin
            mode_step = (req_data.ch == CHAR_SQUOTE) ? MODE_NORMAL : MODE_SQ;
         end
         MODE_DQ: begin
            if (req_data.ch == CHAR_DQUOTE) begin
               mode_step = MODE_NORMAL;
            end else if (req_data.ch == CHAR_BSLASH) begin
               mode_step = MODE_DQ_ESC;
            end else begin
               mode_step = MODE_DQ;
            end
         end
         MODE_DQ_ESC: begin
            mode_step = MODE_DQ;
         end
         default: begin
            // normal mode, and the byte after a '>' that is not a second '>'
            if (mode_ff == MODE_REDIR && req_data.ch == CHAR_GT) begin
               mode_step = MODE_NORMAL;
            end else begin
               case (req_data.ch)
                  CHAR_BSLASH: mode_step = MODE_ESC;
                  CHAR_SQUOTE: mode_step = MODE_SQ;
                  CHAR_DQUOTE: mode_step = MODE_DQ;
                  CHAR_GT:     mode_step = MODE_REDIR;
                  default:     mode_step = MODE_NORMAL;
               endcase
            end
         end
      endcase

      mode_in = mode_ff;
      if (accept) begin
         mode_in = req_data.line_end ? MODE_NORMAL : mode_step;
      end
   end

   // Outputs: which results this byte causes
   always_comb begin
      pre_end   = 1'b0;
      has_byte  = 1'b0;
      redir_end = 1'b0;
      case (mode_ff)
         MODE_ESC, MODE_DQ_ESC: begin
            has_byte = 1'b1;
         end
         MODE_SQ: begin
            has_byte = (req_data.ch != CHAR_SQUOTE);
         end
         MODE_DQ: begin
            has_byte = (req_data.ch != CHAR_DQUOTE) && (req_data.ch != CHAR_BSLASH);
         end
         default: begin
            if (mode_ff == MODE_REDIR && req_data.ch == CHAR_GT) begin
               has_byte  = 1'b1;
               redir_end = 1'b1;
            end else begin
               // a space, or any byte after a lone '>', closes the open token
               pre_end  = token_open_ff &&
                          (mode_ff == MODE_REDIR || req_data.ch == CHAR_SPACE);
               has_byte = (req_data.ch != CHAR_BSLASH) && (req_data.ch != CHAR_SQUOTE) &&
                          (req_data.ch != CHAR_DQUOTE) && (req_data.ch != CHAR_SPACE);
            end
         end
      endcase

      if (redir_end) begin
         token_after = 1'b0;
      end else if (has_byte) begin
         token_after = 1'b1;
      end else begin
         token_after = token_open_ff & ~pre_end;
      end

      q_plan.pre_end    = pre_end;
      q_plan.has_byte   = has_byte;
      q_plan.data       = req_data.ch;
      q_plan.post_end   = redir_end | (req_data.line_end & token_after);
      q_plan.has_status = req_data.line_end;
      q_plan.status_err = ~(mode_step == MODE_NORMAL || mode_step == MODE_REDIR);

      token_open_in = token_open_ff;
      if (accept) begin
         token_open_in = req_data.line_end ? 1'b0 : token_after;
      end

      q_push = accept & (q_plan.pre_end | q_plan.has_byte | q_plan.post_end |
                         q_plan.has_status);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         token_open_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         token_open_ff <= token_open_in;
      end
   end

endmodule

FILE: hdl/sqt_queue.sv
`timescale 1ns / 1ps

module sqt_queue
   import sqt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  plan_type push_data,
   output logic     full,
   input  logic     pop,
   output plan_type head_data,
   output logic     head_valid
);

   plan_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   assign do_push = push & ~full;
   assign do_pop  = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/sqt_back.sv
`timescale 1ns / 1ps

module sqt_back
   import sqt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  plan_type head_data,
   input  logic     head_valid,
   output logic     head_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic [3:0] mask_ff, mask_in;
   logic       started_ff, started_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   logic [3:0] head_mask, live_mask, pick, remain;
   logic       slot_free, issue;

   assign head_mask = {head_data.has_status, head_data.post_end,
                       head_data.has_byte, head_data.pre_end};

   always_comb begin
      // continue a partly issued plan, or start the head one
      live_mask = started_ff ? mask_ff : head_mask;
      pick      = live_mask & (~live_mask + 4'd1);
      remain    = live_mask & ~pick;
      slot_free = ~out_valid_ff | rsp_pop;
      issue     = head_valid & slot_free;
      head_pop  = issue & (remain == 4'd0);

      out_data_in.out_byte = 8'd0;
      out_data_in.run_last = (remain == 4'd0);
      case (pick)
         4'b0010: begin
            out_data_in.kind     = KIND_BYTE;
            out_data_in.out_byte = head_data.data;
         end
         4'b1000: begin
            out_data_in.kind = head_data.status_err ? KIND_ERR : KIND_OK;
         end
         default: begin
            out_data_in.kind = KIND_END;
         end
      endcase

      mask_in    = mask_ff;
      started_in = started_ff;
      if (issue) begin
         mask_in    = remain;
         started_in = (remain != 4'd0);
      end

      if (issue) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= 4'd0;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         started_ff   <= started_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: hdl/shell_quote_tokenizer.sv
`timescale 1ns / 1ps
// The first result of a byte passes through a plan queue slot and the output register.
// One byte is accepted per cycle unless the queue is full; the back end issues one result
//    per cycle while its output is free or popped; a byte holds it for up to four results.
// A four-entry plan queue absorbs bursts; req_full rises only when it is full.
// Reset is synchronous: quoting mode, open-token flag, queue and output valid flag clear.

module shell_quote_tokenizer
   import sqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic     q_push, q_full, head_valid, head_pop;
   plan_type q_plan, head_data;

   sqt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_plan   (q_plan)
   );

   sqt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_plan),
      .full       (q_full),
      .pop        (head_pop),
      .head_data  (head_data),
      .head_valid (head_valid)
   );

   sqt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   assign req_full = q_full;

endmodule

FILE: hdl/sqt_checker.sv
`timescale 1ns / 1ps

module sqt_checker
   import sqt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input req_type req_data,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // hold a waiting result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before pop");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind != KIND_BYTE) |-> (rsp_data.out_byte == 8'd0))
      else $error("non-byte result carries a byte");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.kind == KIND_OK || rsp_data.kind == KIND_ERR))
      |-> rsp_data.run_last)
      else $error("line status is not the last result of its byte");

   // a line-end item always yields a status, so a result shows up soon after
   a_line_status: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_data.line_end) |=> ##1 !rsp_empty)
      else $error("line end produced no result");

endmodule

bind shell_quote_tokenizer sqt_checker u_sqt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

FILE: sim/shell_quote_tokenizer_checker.sv
`timescale 1ns / 1ps

module sqt_token_checker
   import sqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_data,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      results_seen,
   output int      unterminated_lines
);

   mode_type    cur_mode = MODE_NORMAL;
   logic        in_token = 1'b0;
   int unsigned byte_results;
   rsp_type     token_stream_q[$];

   function automatic void add_result(logic [1:0] kind, logic [7:0] b);
      rsp_type r;
      r.kind     = kind;
      r.out_byte = (kind == KIND_BYTE) ? b : 8'h00;
      r.run_last = 1'b0;
      token_stream_q = {token_stream_q, r};
      byte_results++;
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      add_result(KIND_BYTE, b);
      in_token = 1'b1;
   endfunction

   function automatic void close_token();
      if (in_token) begin
         add_result(KIND_END, 8'h00);
         in_token = 1'b0;
      end
   endfunction

   function automatic void plain_byte(logic [7:0] c);
      case (c)
         CHAR_BSLASH: cur_mode = MODE_ESC;
         CHAR_SQUOTE: cur_mode = MODE_SQ;
         CHAR_DQUOTE: cur_mode = MODE_DQ;
         CHAR_GT: begin
            emit_byte(c);
            cur_mode = MODE_REDIR;
         end
         CHAR_SPACE: close_token();
         default: emit_byte(c);
      endcase
   endfunction

   // Append every result one input byte causes, then flag the last of them.
   function automatic void tokenize_byte(req_type item);
      rsp_type tail;
      logic    line_ok;
      byte_results = 0;
      case (cur_mode)
         MODE_ESC: begin
            emit_byte(item.ch);
            cur_mode = MODE_NORMAL;
         end
         MODE_SQ: begin
            if (item.ch == CHAR_SQUOTE) cur_mode = MODE_NORMAL;
            else emit_byte(item.ch);
         end
         MODE_DQ: begin
            if (item.ch == CHAR_DQUOTE) cur_mode = MODE_NORMAL;
            else if (item.ch == CHAR_BSLASH) cur_mode = MODE_DQ_ESC;
            else emit_byte(item.ch);
         end
         MODE_DQ_ESC: begin
            emit_byte(item.ch);
            cur_mode = MODE_DQ;
         end
         MODE_REDIR: begin
            cur_mode = MODE_NORMAL;
            if (item.ch == CHAR_GT) begin
               emit_byte(item.ch);
               close_token();
            end else begin
               // a lone '>' ends the token; the byte still counts
               close_token();
               plain_byte(item.ch);
            end
         end
         default: begin
            cur_mode = MODE_NORMAL;
            plain_byte(item.ch);
         end
      endcase
      if (item.line_end) begin
         line_ok = (cur_mode == MODE_NORMAL) || (cur_mode == MODE_REDIR);
         close_token();
         add_result(line_ok ? KIND_OK : KIND_ERR, 8'h00);
         if (!line_ok) unterminated_lines++;
         cur_mode = MODE_NORMAL;
         in_token = 1'b0;
      end
      if (byte_results > 0) begin
         tail = token_stream_q[token_stream_q.size() - 1];
         tail.run_last = 1'b1;
         token_stream_q[token_stream_q.size() - 1] = tail;
      end
   endfunction

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                  $time, what, want.kind, want.out_byte, want.run_last,
                  got.kind, got.out_byte, got.run_last);
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cur_mode = MODE_NORMAL;
         in_token = 1'b0;
         token_stream_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (token_stream_q.size() == 0) begin
               report_mismatch("result with none expected", '0, rsp_data);
            end else begin
               want = token_stream_q.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                   rsp_data.run_last !== want.run_last)
                  report_mismatch("result mismatch", want, rsp_data);
            end
         end
         if (req_push && !req_full) tokenize_byte(req_data);
      end
      pending = token_stream_q.size();
   end

endmodule

FILE: sim/tb_shell_quote_tokenizer.sv
`timescale 1ns / 1ps

module tb_shell_quote_tokenizer;
   import sqt_pkg::*;

   typedef enum {
      PIECE_WORD, PIECE_GAP, PIECE_SQUOTED, PIECE_DQUOTED, PIECE_ESCAPE, PIECE_REDIR
   } piece_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   int      fail_count;
   int      pending_results;
   int      results_seen;
   int      unterminated_lines;

   int      send_idle_pct = 0;
   int      pop_stall_pct = 0;
   logic    pressure_on   = 1'b0;
   logic    hold_pop      = 1'b0;
   int      bytes_sent    = 0;
   int      lines_sent    = 0;
   req_type line_q[$];

   shell_quote_tokenizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   sqt_token_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data           (req_data),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_data           (rsp_data),
      .fail_count         (fail_count),
      .pending            (pending_results),
      .results_seen       (results_seen),
      .unterminated_lines (unterminated_lines)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         rsp_pop <= !hold_pop && ($urandom_range(0, 99) >= pop_stall_pct);
      end
   end

   // Hold off the receiver long enough for the block to fill and stall its input.
   initial begin
      wait (pressure_on);
      @(posedge clock);
      hold_pop <= 1'b1;
      repeat (60) @(posedge clock);
      hold_pop <= 1'b0;
   end

   task automatic send_item(req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic push_byte(logic [7:0] c);
      req_type item;
      item.ch       = c;
      item.line_end = 1'b0;
      line_q = {line_q, item};
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic send_line();
      req_type item;
      item = line_q[line_q.size() - 1];
      item.line_end = 1'b1;
      line_q[line_q.size() - 1] = item;
      while (line_q.size() > 0) begin
         item = line_q.pop_front();
         send_item(item);
      end
      lines_sent++;
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_BSLASH || c == CHAR_SQUOTE || c == CHAR_DQUOTE ||
             c == CHAR_GT || c == CHAR_SPACE);
      return c;
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 4))
         0: return CHAR_BSLASH;
         1: return CHAR_SQUOTE;
         2: return CHAR_DQUOTE;
         3: return CHAR_GT;
         default: return CHAR_SPACE;
      endcase
   endfunction

   // Mostly well-formed lines with random content; some noise and some cut short.
   task automatic build_random_line();
      int unsigned n;
      logic [7:0]  c;
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            if ($urandom_range(0, 1)) c = special_char();
            else c = 8'($urandom_range(0, 255));
            push_byte(c);
         end
      end else begin
         repeat ($urandom_range(1, 5)) begin
            case (piece_type'($urandom_range(0, 5)))
               PIECE_WORD: repeat ($urandom_range(1, 4)) push_byte(plain_char());
               PIECE_GAP: repeat ($urandom_range(1, 2)) push_byte(CHAR_SPACE);
               PIECE_SQUOTED: begin
                  push_byte(CHAR_SQUOTE);
                  repeat ($urandom_range(0, 3)) begin
                     do c = 8'($urandom_range(0, 255)); while (c == CHAR_SQUOTE);
                     push_byte(c);
                  end
                  push_byte(CHAR_SQUOTE);
               end
               PIECE_DQUOTED: begin
                  push_byte(CHAR_DQUOTE);
                  repeat ($urandom_range(0, 3)) begin
                     if ($urandom_range(0, 3) == 0) begin
                        push_byte(CHAR_BSLASH);
                        push_byte(8'($urandom_range(0, 255)));
                     end else begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == CHAR_DQUOTE || c == CHAR_BSLASH);
                        push_byte(c);
                     end
                  end
                  push_byte(CHAR_DQUOTE);
               end
               PIECE_ESCAPE: begin
                  push_byte(CHAR_BSLASH);
                  push_byte(8'($urandom_range(0, 255)));
               end
               default: begin
                  push_byte(CHAR_GT);
                  if ($urandom_range(0, 1)) push_byte(CHAR_GT);
                  if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) push_byte(plain_char());
               end
            endcase
         end
         if ($urandom_range(0, 99) < 10 && line_q.size() > 1) void'(line_q.pop_back());
      end
   endtask

   task automatic run_random(int count);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < count) begin
         build_random_line();
         send_line();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_text("a b");
      send_line();
      // empty quotes, then a '>' closing the line
      push_text("'' >");
      send_line();
      // double redirect, then a lone one followed by a real byte
      push_text(">>>");
      push_byte(8'hFF);
      send_line();
      push_text("\"\\\"\"");
      send_line();
      // line cut off inside double quotes after an escape
      push_text("\"a\\\"");
      send_line();
      push_text("\\");
      send_line();
      push_text("'q");
      send_line();
      push_byte(8'h00);
      push_text("\\ ");
      send_line();
      push_text(" ");
      send_line();

      pressure_on = 1'b1;
      run_random(75);
      send_idle_pct = 61;
      run_random(75);
      send_idle_pct = 0;
      pop_stall_pct = 61;
      run_random(75);
      send_idle_pct = 18;
      pop_stall_pct = 18;
      run_random(75);
      req_push <= 1'b0;

      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes in %0d lines across four idle/stall mixes and one long hold-off.",
               bytes_sent, lines_sent);
      $display("Checked %0d results; %0d lines ended with an open quote or escape.",
               results_seen, unterminated_lines);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: shell_quote_tokenizer.f
hdl/sqt_pkg.sv
hdl/sqt_front.sv
hdl/sqt_queue.sv
hdl/sqt_back.sv
hdl/shell_quote_tokenizer.sv
hdl/sqt_checker.sv
sim/shell_quote_tokenizer_checker.sv
sim/tb_shell_quote_tokenizer.sv
